/* src/taylor_sine_core_defines.svh */
// Assertion macros for the taylor sine core.
// Needs clk and arst_n in the scope of each use.
`ifndef TAYLOR_SINE_CORE_DEFINES_SVH
`define TAYLOR_SINE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TSIN_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is delayed by the argument n.
`define TSIN_ASSERT_LAT(label, ante, n, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

/* src/tsin_pkg.sv */
// Constants, widths and coefficient table of the taylor sine core.
// Depends on nothing; used by taylor_sine_core.
package tsin_pkg;

	localparam int TERMS      = 10;
	localparam int HSTEPS     = TERMS - 1;
	localparam int COEF_COUNT = 12;

	localparam int ANGLE_W   = 32;
	localparam int SINE_W    = 32;
	localparam int DIV_STEPS = 6;             // quotient of |angle|/pi stays below 64
	localparam int REM_W     = 64;            // |angle| in Q.56
	localparam int R_W       = 58;            // remainder below pi in Q.56
	localparam int U_W       = 31;            // reduced angle in Q.30
	localparam int U2_W      = 32;            // its square in Q.30
	localparam int SH_W      = 30;            // Horner operand, below 1/3! in Q.32
	localparam int COEF_W    = 33;            // Q.32 up to 1.0
	localparam int SQ_W      = 2 * U_W;
	localparam int HP_W      = SH_W + U2_W;
	localparam int YP_W      = COEF_W + U_W;

	localparam int U_SH  = 26;
	localparam int U2_SH = 30;
	localparam int T_SH  = 30;
	localparam int Y_SH  = 32;

	// abs, divide steps, reflect, round, square, round, two per Horner step,
	// final multiply, output
	localparam int LATENCY = 13 + 2 * HSTEPS;

	localparam logic [R_W-1:0]    PI56    = 58'h3243F6A8885A309;
	localparam logic [R_W-1:0]    HPI56   = 58'h1921FB54442D184;
	localparam logic [COEF_W-1:0] ONE_Q30 = 33'h040000000;

	// 1/(2i+1)! in Q.32, rounded to nearest
	localparam logic [COEF_W-1:0] INV_ODD_FACT [COEF_COUNT] = '{
		33'd4294967296,
		33'd715827883,
		33'd35791394,
		33'd852176,
		33'd11836,
		33'd108,
		33'd1,
		33'd0, 33'd0, 33'd0, 33'd0, 33'd0
	};

	function automatic logic [COEF_W-1:0] coef(input int i);
		if (i < 0 || i >= COEF_COUNT) begin
			return '0;
		end
		return INV_ODD_FACT[i];
	endfunction

endpackage

/* src/taylor_sine_core.sv */
// Taylor sine core: Q8.24 angle in, Q2.30 sine out, fully pipelined.
// Depends on tsin_pkg and taylor_sine_core_defines.svh.
//
//   channel   handshake          payload            dir
//   command   start / busy       angle  [31:0] s    in
//   result    strobe (1 cycle)   sine   [31:0] s    out
//
// One word enters per cycle; busy stays low since nothing ever waits.
// Each result passes the magnitude stage, six divide steps, reflect, round, square,
// round, two stages per Horner step, the final multiply and the output register.
// Reset clears the valid bits of all stages; words in flight are dropped.
// The receiver cannot stall: strobe marks sine for exactly one cycle.
`include "taylor_sine_core_defines.svh"

module taylor_sine_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [tsin_pkg::ANGLE_W-1:0] angle,
	output logic                                strobe,
	output logic signed [tsin_pkg::SINE_W-1:0]  sine
);
	import tsin_pkg::*;

	assign busy = 1'b0;

	// ---------------- stage 1: magnitude ----------------
	logic               vld_s1;
	logic               neg_s1;
	logic [ANGLE_W-1:0] mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= angle[ANGLE_W-1];
		mag_s1 <= angle[ANGLE_W-1] ? ANGLE_W'(~angle + 1'b1) : ANGLE_W'(angle);
	end

	// ---------------- restoring divide by pi, one quotient bit per stage ----------------
	logic             dv_vld_s [DIV_STEPS];
	logic [REM_W-1:0] dv_rem_s [DIV_STEPS];
	logic             dv_sgn_s [DIV_STEPS];

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		localparam logic [REM_W-1:0] DSOR = REM_W'(PI56) << (DIV_STEPS - 1 - g);
		logic             vin;
		logic             nin;
		logic [REM_W-1:0] rin;
		logic             take;

		if (g == 0) begin : g_first
			assign vin = vld_s1;
			assign nin = neg_s1;
			assign rin = {mag_s1, {(REM_W - ANGLE_W){1'b0}}};
		end else begin : g_next
			assign vin = dv_vld_s[g-1];
			assign nin = dv_sgn_s[g-1];
			assign rin = dv_rem_s[g-1];
		end

		assign take = (rin >= DSOR);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[g] <= 1'b0;
			end else begin
				dv_vld_s[g] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			dv_rem_s[g] <= take ? rin - DSOR : rin;
		end

		// the last step decides the parity of k: fold it into the sign
		if (g == DIV_STEPS - 1) begin : g_par
			always_ff @(posedge clk) begin
				dv_sgn_s[g] <= nin ^ take;
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				dv_sgn_s[g] <= nin;
			end
		end
	end

	// ---------------- reflect into [0, pi/2] ----------------
	logic           rf_vld_s;
	logic           rf_sgn_s;
	logic [R_W-1:0] rf_r_s;
	logic [R_W-1:0] rem_fin;

	assign rem_fin = dv_rem_s[DIV_STEPS-1][R_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_s <= 1'b0;
		end else begin
			rf_vld_s <= dv_vld_s[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		rf_sgn_s <= dv_sgn_s[DIV_STEPS-1];
		rf_r_s   <= (rem_fin > HPI56) ? PI56 - rem_fin : rem_fin;
	end

	// ---------------- round to Q.30 ----------------
	logic           ur_vld_s;
	logic           ur_sgn_s;
	logic [U_W-1:0] ur_u_s;
	logic [R_W:0]   rsum;

	assign rsum = {1'b0, rf_r_s} + ((R_W + 1)'(1) << (U_SH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ur_vld_s <= 1'b0;
		end else begin
			ur_vld_s <= rf_vld_s;
		end
	end

	always_ff @(posedge clk) begin
		ur_sgn_s <= rf_sgn_s;
		ur_u_s   <= rsum[U_SH+U_W-1:U_SH];
	end

	// ---------------- square ----------------
	logic            sq_vld_s;
	logic            sq_sgn_s;
	logic [U_W-1:0]  sq_u_s;
	logic [SQ_W-1:0] sq_p_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s <= 1'b0;
		end else begin
			sq_vld_s <= ur_vld_s;
		end
	end

	always_ff @(posedge clk) begin
		sq_sgn_s <= ur_sgn_s;
		sq_u_s   <= ur_u_s;
		sq_p_s   <= SQ_W'(ur_u_s) * SQ_W'(ur_u_s);
	end

	// ---------------- round the square ----------------
	logic            u2_vld_s;
	logic            u2_sgn_s;
	logic [U_W-1:0]  u2_u_s;
	logic [U2_W-1:0] u2_v_s;
	logic [SQ_W:0]   sqsum;

	assign sqsum = {1'b0, sq_p_s} + ((SQ_W + 1)'(1) << (U2_SH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u2_vld_s <= 1'b0;
		end else begin
			u2_vld_s <= sq_vld_s;
		end
	end

	always_ff @(posedge clk) begin
		u2_sgn_s <= sq_sgn_s;
		u2_u_s   <= sq_u_s;
		u2_v_s   <= sqsum[U2_SH+U2_W-1:U2_SH];
	end

	// ---------------- Horner: multiply stage, then subtract stage ----------------
	logic              hm_vld_s [HSTEPS];
	logic              hm_sgn_s [HSTEPS];
	logic [U_W-1:0]    hm_u_s   [HSTEPS];
	logic [U2_W-1:0]   hm_u2_s  [HSTEPS];
	logic [HP_W-1:0]   hm_p_s   [HSTEPS];
	logic              hb_vld_s [HSTEPS];
	logic              hb_sgn_s [HSTEPS];
	logic [U_W-1:0]    hb_u_s   [HSTEPS];
	logic [U2_W-1:0]   hb_u2_s  [HSTEPS];
	logic [COEF_W-1:0] hb_s_s   [HSTEPS];

	for (genvar m = 0; m < HSTEPS; m++) begin : g_hor
		localparam logic [COEF_W-1:0] CI = coef(TERMS - 2 - m);
		logic              vin;
		logic              nin;
		logic [U_W-1:0]    uin;
		logic [U2_W-1:0]   u2in;
		logic [COEF_W-1:0] sin_w;
		logic [HP_W:0]     tsum;
		logic [COEF_W-1:0] t;

		if (m == 0) begin : g_first
			assign vin   = u2_vld_s;
			assign nin   = u2_sgn_s;
			assign uin   = u2_u_s;
			assign u2in  = u2_v_s;
			assign sin_w = coef(TERMS - 1);
		end else begin : g_next
			assign vin   = hb_vld_s[m-1];
			assign nin   = hb_sgn_s[m-1];
			assign uin   = hb_u_s[m-1];
			assign u2in  = hb_u2_s[m-1];
			assign sin_w = hb_s_s[m-1];
		end

		assign tsum = {1'b0, hm_p_s[m]} + ((HP_W + 1)'(1) << (T_SH - 1));
		assign t    = tsum[T_SH+COEF_W-1:T_SH];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hm_vld_s[m] <= 1'b0;
				hb_vld_s[m] <= 1'b0;
			end else begin
				hm_vld_s[m] <= vin;
				hb_vld_s[m] <= hm_vld_s[m];
			end
		end

		// running sum stays below 1/3! here, so its low bits carry it
		always_ff @(posedge clk) begin
			hm_sgn_s[m] <= nin;
			hm_u_s[m]   <= uin;
			hm_u2_s[m]  <= u2in;
			hm_p_s[m]   <= HP_W'(sin_w[SH_W-1:0]) * HP_W'(u2in);
			hb_sgn_s[m] <= hm_sgn_s[m];
			hb_u_s[m]   <= hm_u_s[m];
			hb_u2_s[m]  <= hm_u2_s[m];
			hb_s_s[m]   <= (CI >= t) ? CI - t : '0;
		end
	end

	// ---------------- final multiply by u ----------------
	logic            ym_vld_s;
	logic            ym_sgn_s;
	logic [YP_W-1:0] ym_p_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ym_vld_s <= 1'b0;
		end else begin
			ym_vld_s <= hb_vld_s[HSTEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		ym_sgn_s <= hb_sgn_s[HSTEPS-1];
		ym_p_s   <= YP_W'(hb_s_s[HSTEPS-1]) * YP_W'(hb_u_s[HSTEPS-1]);
	end

	// ---------------- round, clamp, sign ----------------
	logic [YP_W:0]     ysum;
	logic [COEF_W-1:0] yraw;
	logic [COEF_W-1:0] ysat;

	assign ysum = {1'b0, ym_p_s} + ((YP_W + 1)'(1) << (Y_SH - 1));
	assign yraw = ysum[Y_SH+COEF_W-1:Y_SH];
	assign ysat = (yraw > ONE_Q30) ? ONE_Q30 : yraw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= ym_vld_s;
		end
	end

	always_ff @(posedge clk) begin
		sine <= ym_sgn_s ? -$signed(ysat[SINE_W-1:0]) : $signed(ysat[SINE_W-1:0]);
	end

	// ---------------- checks ----------------
	`TSIN_ASSERT_LAT(a_word_arrives, start && !busy, LATENCY, strobe, "accepted word lost")
	`TSIN_ASSERT_IMP(a_no_ghost, strobe, $past(start && !busy, LATENCY), "result without word")
	`TSIN_ASSERT_IMP(a_sat, strobe, (sine <= 32'sd1073741824) && (sine >= -32'sd1073741824), "sine out of range")
	`TSIN_ASSERT_LAT(a_zero, start && !busy && angle == '0, LATENCY, sine == '0, "sine of zero not zero")

endmodule

/* tb/sv/taylor_sine_checker.sv */
// Checker for taylor_sine_core: watches the command and result channels, predicts each sine
// from its angle and compares the results in order. Depends on tsin_pkg for the widths and
// the number of Horner terms.
module taylor_sine_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic signed [tsin_pkg::ANGLE_W-1:0] angle,
	input  logic                                strobe,
	input  logic signed [tsin_pkg::SINE_W-1:0]  sine,
	output int                                  mismatches,
	output int                                  outstanding,
	output int                                  checked
);

	localparam int          POLY_TERMS  = tsin_pkg::TERMS;
	localparam int          REPORT_MAX  = 10;
	localparam logic [63:0] PI_Q56      = 64'h03243F6A8885A309;
	localparam logic [63:0] HALF_PI_Q56 = 64'h01921FB54442D184;
	localparam logic [63:0] UNITY_Q30   = 64'h0000000040000000;

	logic [tsin_pkg::SINE_W-1:0] sine_q [$];
	int                          miss_count = 0;
	int                          pass_count = 0;

	// 1/(2i+1)! in Q.32, rounded to nearest
	function automatic logic [63:0] inv_odd_factorial(input int i);
		case (i)
			0:       return 64'd4294967296;
			1:       return 64'd715827883;
			2:       return 64'd35791394;
			3:       return 64'd852176;
			4:       return 64'd11836;
			5:       return 64'd108;
			6:       return 64'd1;
			default: return 64'd0;
		endcase
	endfunction

	function automatic logic [tsin_pkg::SINE_W-1:0] predict_sine(
		input logic [tsin_pkg::ANGLE_W-1:0] raw
	);
		logic        neg;
		logic [63:0] mag, a_q56, half_turns, r, u, u_sq, s, t, c, y;
		int          i;
		neg        = raw[tsin_pkg::ANGLE_W-1];
		mag        = neg ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
		a_q56      = mag << 32;
		half_turns = a_q56 / PI_Q56;
		r          = a_q56 - half_turns * PI_Q56;
		// fold the remainder into [0, pi/2]
		if (r > HALF_PI_Q56) begin
			r = PI_Q56 - r;
		end
		u    = (r + (64'd1 << 25)) >> 26;
		u_sq = (u * u + (64'd1 << 29)) >> 30;
		s    = inv_odd_factorial(POLY_TERMS - 1);
		for (i = POLY_TERMS - 2; i >= 0; i--) begin
			t = (s * u_sq + (64'd1 << 29)) >> 30;
			c = inv_odd_factorial(i);
			// clamp at zero instead of wrapping
			s = (c >= t) ? (c - t) : 64'd0;
		end
		y = (s * u + (64'd1 << 31)) >> 32;
		if (y > UNITY_Q30) begin
			y = UNITY_Q30;
		end
		if (neg ^ half_turns[0]) begin
			y = 64'd0 - y;
		end
		return y[tsin_pkg::SINE_W-1:0];
	endfunction

	task automatic report_miss(input string what);
		miss_count++;
		if (miss_count <= REPORT_MAX) begin
			$display("[%0t] checker: %s", $realtime, what);
		end
	endtask

	always @(posedge clk) begin
		logic [tsin_pkg::SINE_W-1:0] want;
		if (arst_n) begin
			// retire the result before queuing the new word: they cannot pair up
			if (strobe) begin
				if (sine_q.size() == 0) begin
					report_miss($sformatf("unexpected sine word 0x%08h", sine));
				end else begin
					want = sine_q.pop_front();
					if (sine !== want) begin
						report_miss($sformatf("sine expected 0x%08h (%0d) got 0x%08h (%0d)",
							want, $signed(want), sine, sine));
					end else begin
						pass_count++;
					end
				end
			end
			if (start && !busy) begin
				sine_q.push_back(predict_sine(angle));
			end
		end
		mismatches  <= miss_count;
		outstanding <= sine_q.size();
		checked     <= pass_count;
	end

endmodule

/* tb/sv/tb_top.sv */
// Top of the taylor_sine_core testbench: clock, reset, angle stimulus in four pacing phases,
// watchdog and verdict. Depends on tsin_pkg, taylor_sine_core and taylor_sine_checker.
module tb_top;

	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          PHASE_WORDS    = 325;
	localparam int          HALF_PI_Q24    = 26353589;
	localparam int          PI_Q24         = 52707179;
	localparam int          PHASE_COUNT    = 4;
	localparam int          IDLE_PCT [PHASE_COUNT] = '{0, 78, 0, 29};

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                start = 1'b0;
	logic                                busy;
	logic signed [tsin_pkg::ANGLE_W-1:0] angle = '0;
	logic                                strobe;
	logic signed [tsin_pkg::SINE_W-1:0]  sine;

	int mismatches;
	int outstanding;
	int checked;
	int idle_pct = 0;
	int words_sent = 0;
	int quiet_cycles = 0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	taylor_sine_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.angle  (angle),
		.strobe (strobe),
		.sine   (sine)
	);

	taylor_sine_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.angle       (angle),
		.strobe      (strobe),
		.sine        (sine),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked)
	);

	// count cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((start && !busy) || strobe) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_angle(input logic [tsin_pkg::ANGLE_W-1:0] a);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			angle <= $urandom;
			@(posedge clk);
		end
		start <= 1'b1;
		angle <= a;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		words_sent++;
	endtask

	// full-range noise, angles within two turns, or angles near a multiple of pi/2
	function automatic logic [tsin_pkg::ANGLE_W-1:0] random_angle();
		longint a;
		int     pick;
		pick = $urandom_range(9);
		if (pick < 4) begin
			a = $urandom;
		end else if (pick < 7) begin
			a = longint'($urandom_range(4 * PI_Q24)) - 2 * PI_Q24;
		end else begin
			a = longint'($urandom_range(81)) * HALF_PI_Q24 + $urandom_range(64) - 32;
			if ($urandom_range(1)) begin
				a = -a;
			end
		end
		return a[tsin_pkg::ANGLE_W-1:0];
	endfunction

	initial begin
		logic [tsin_pkg::ANGLE_W-1:0] directed [$];
		directed = '{32'd0, 32'd1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000001,
			HALF_PI_Q24, HALF_PI_Q24 - 1, -HALF_PI_Q24, PI_Q24 - 1, PI_Q24, PI_Q24 + 1,
			-PI_Q24, 3 * HALF_PI_Q24, -3 * HALF_PI_Q24, 2 * PI_Q24, 32'h00FFFFFF,
			32'h01000000, -32'h01000000, 32'h55555555, 32'hAAAAAAAA};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			send_angle(directed[i]);
		end
		for (int p = 0; p < PHASE_COUNT; p++) begin
			idle_pct = IDLE_PCT[p];
			repeat (PHASE_WORDS) send_angle(random_angle());
		end
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (tsin_pkg::LATENCY + 8) @(posedge clk);
		$display("Sent %0d angles (directed corners, then random in four pacing phases)",
			words_sent);
		$display("Matched %0d sine words, %0d mismatches", checked, mismatches);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
